@@ design/dpd_pkg.sv @@
package dpd_pkg;

	// Largest payload plus one; a byte that would reach this count is an overflow
	localparam int PAYLOAD_CAP = 1024;
	localparam int COUNT_W = $clog2(PAYLOAD_CAP);
	localparam int LEN_W = 10;
	localparam int LEN_MAX = 1023;

	// Framing characters
	localparam logic [7:0] CH_START = 8'h24;  // '$'
	localparam logic [7:0] CH_END = 8'h23;    // '#'

	// Receiver phase, one-hot
	typedef enum logic [3:0] {
		PH_HUNT = 4'b0001,
		PH_DATA = 4'b0010,
		PH_DIG1 = 4'b0100,
		PH_DIG2 = 4'b1000
	} phase_t;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_DATA = 3'd0,
		KIND_GOOD = 3'd1,
		KIND_MISMATCH = 3'd2,
		KIND_OVERFLOW = 3'd3,
		KIND_BAD_DIGIT = 3'd4
	} kind_t;

	// Acknowledge codes
	typedef enum logic [1:0] {
		ACK_NONE = 2'd0,
		ACK_PLUS = 2'd1,
		ACK_MINUS = 2'd2
	} ack_t;

	typedef struct packed {
		phase_t phase;
		logic [7:0] sum;
		logic [COUNT_W-1:0] count;
		logic [3:0] nibble;
		logic hi_ok;
	} state_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] data;
		logic [LEN_W-1:0] len;
		ack_t ack;
	} result_t;

endpackage

@@ design/debug_packet_deframer.sv @@
// Packet deframer for a debug serial link. Takes one byte per cycle unless
// in_stall holds it: drops bytes until '$', passes payload bytes out one
// result each while summing them modulo 256, and after '#' reads two hex digits
// and reports a verdict (good, mismatch or bad digits) with the payload length
// and an ack code; an over-long payload is reported as an overflow instead.
// Throughput is one byte per cycle when neither side stalls. A byte goes into an
// input register, its result, if any, into the result register, decided by the
// framing state machine between them combinationally. in_stall rises only when
// the input register holds a byte and the result register is full and stalled.
module debug_packet_deframer (
	input logic clk,
	input logic arst_n,
	input logic no_ack_we,
	input logic no_ack_wdata,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] result_kind,
	output logic [7:0] data_byte,
	output logic [9:0] payload_length,
	output logic [1:0] ack_code
);

	logic no_ack_q;
	logic vld_s1;
	logic [7:0] rx_s1;
	logic vld_s2;
	dpd_pkg::result_t res_s2;
	dpd_pkg::state_t st_q;
	dpd_pkg::state_t st_nxt;
	dpd_pkg::result_t res;
	logic res_valid;
	logic out_blocked;
	logic advance;

	dpd_step u_step (
		.st(st_q),
		.rx(rx_s1),
		.no_ack(no_ack_q),
		.st_nxt(st_nxt),
		.res_valid(res_valid),
		.res(res)
	);

	// Handshake control
	assign out_blocked = vld_s2 && out_stall;
	assign advance = vld_s1 && !out_blocked;
	assign in_stall = vld_s1 && out_blocked;

	// Config register, input stage, state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_ack_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			st_q.phase <= dpd_pkg::PH_HUNT;
			st_q.sum <= 8'd0;
			st_q.count <= '0;
			st_q.nibble <= 4'd0;
			st_q.hi_ok <= 1'b0;
		end else begin
			if (no_ack_we) begin
				no_ack_q <= no_ack_wdata;
			end
			if (!in_stall) begin
				vld_s1 <= in_valid;
			end
			if (advance) begin
				st_q <= st_nxt;
			end
			if (!out_blocked) begin
				vld_s2 <= advance && res_valid;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_s1 <= rx_byte;
		end
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid = vld_s2;
	assign result_kind = res_s2.kind;
	assign data_byte = res_s2.data;
	assign payload_length = res_s2.len;
	assign ack_code = res_s2.ack;

	// Payload byte results carry no length and no ack
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.kind == dpd_pkg::KIND_DATA) |->
			(res_s2.len == '0 && res_s2.ack == dpd_pkg::ACK_NONE))
		else $error("payload byte result with length or ack");

	// An ack is only given on a checksum verdict outside no-ack mode
	a_ack_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.ack != dpd_pkg::ACK_NONE) |->
			((res_s2.kind == dpd_pkg::KIND_GOOD || res_s2.kind == dpd_pkg::KIND_MISMATCH)
			&& !no_ack_q))
		else $error("ack code on wrong result");

	// Any verdict sends the receiver back to hunting
	a_verdict_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && res.kind != dpd_pkg::KIND_DATA) |=>
			(st_q.phase == dpd_pkg::PH_HUNT))
		else $error("no return to hunt after verdict");

	// A stalled input is only possible with a byte held in the input stage
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2))
		else $error("input stalled with free stages");

endmodule

@@ design/dpd_step.sv @@
module dpd_step (
	input dpd_pkg::state_t st,
	input logic [7:0] rx,
	input logic no_ack,
	output dpd_pkg::state_t st_nxt,
	output logic res_valid,
	output dpd_pkg::result_t res
);

	logic dig_ok;
	logic [3:0] dig_val;
	logic at_cap;
	logic [dpd_pkg::LEN_W-1:0] len_out;

	// Hex digit decode, either case
	always_comb begin
		dig_ok = 1'b1;
		dig_val = 4'd0;
		if (rx >= 8'h30 && rx <= 8'h39) begin
			dig_val = 4'(rx - 8'h30);
		end else if (rx >= 8'h61 && rx <= 8'h66) begin
			dig_val = 4'(rx - 8'h61 + 8'd10);
		end else if (rx >= 8'h41 && rx <= 8'h46) begin
			dig_val = 4'(rx - 8'h41 + 8'd10);
		end else begin
			dig_ok = 1'b0;
		end
	end

	// Capacity check and saturated length
	assign at_cap = (32'(st.count) >= dpd_pkg::PAYLOAD_CAP - 1);
	assign len_out = (32'(st.count) > dpd_pkg::LEN_MAX) ?
		dpd_pkg::LEN_W'(dpd_pkg::LEN_MAX) : dpd_pkg::LEN_W'(st.count);

	// Framing state machine
	always_comb begin
		st_nxt = st;
		res_valid = 1'b0;
		res.kind = dpd_pkg::KIND_DATA;
		res.data = 8'd0;
		res.len = '0;
		res.ack = dpd_pkg::ACK_NONE;
		unique case (st.phase)
			dpd_pkg::PH_HUNT: begin
				if (rx == dpd_pkg::CH_START) begin
					st_nxt.phase = dpd_pkg::PH_DATA;
					st_nxt.sum = 8'd0;
					st_nxt.count = '0;
				end
			end
			dpd_pkg::PH_DATA: begin
				if (rx == dpd_pkg::CH_END) begin
					st_nxt.phase = dpd_pkg::PH_DIG1;
				end else if (at_cap) begin
					// payload full: drop the byte and report
					res_valid = 1'b1;
					res.kind = dpd_pkg::KIND_OVERFLOW;
					res.len = len_out;
					st_nxt.phase = dpd_pkg::PH_HUNT;
				end else begin
					res_valid = 1'b1;
					res.data = rx;
					st_nxt.count = st.count + dpd_pkg::COUNT_W'(1);
					st_nxt.sum = st.sum + rx;
				end
			end
			dpd_pkg::PH_DIG1: begin
				st_nxt.hi_ok = dig_ok;
				st_nxt.nibble = dig_ok ? dig_val : 4'd0;
				st_nxt.phase = dpd_pkg::PH_DIG2;
			end
			dpd_pkg::PH_DIG2: begin
				st_nxt.phase = dpd_pkg::PH_HUNT;
				res_valid = 1'b1;
				res.len = len_out;
				if (!dig_ok || !st.hi_ok) begin
					res.kind = dpd_pkg::KIND_BAD_DIGIT;
				end else if ({st.nibble, dig_val} == st.sum) begin
					res.kind = dpd_pkg::KIND_GOOD;
					res.ack = no_ack ? dpd_pkg::ACK_NONE : dpd_pkg::ACK_PLUS;
				end else begin
					res.kind = dpd_pkg::KIND_MISMATCH;
					res.ack = no_ack ? dpd_pkg::ACK_NONE : dpd_pkg::ACK_MINUS;
				end
			end
			default: begin
				st_nxt.phase = dpd_pkg::PH_HUNT;
			end
		endcase
	end

endmodule

@@ test/debug_packet_deframer_tb.sv @@
`timescale 1ns / 1ps

module debug_packet_deframer_tb;

	localparam int SETTLE_CYCLES = 8;    // the result register sits behind the input register
	localparam int STUCK_LIMIT = 4000;   // cycles with no request moving on either side
	localparam int PHASES = 8;
	localparam int PHASE_BYTES = 55;     // framed bytes per random phase
	localparam int PRINT_CAP = 100;

	logic clk;
	logic arst_n = 1'b0;
	logic no_ack_we = 1'b0;
	logic no_ack_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] result_kind;
	logic [7:0] data_byte;
	logic [9:0] payload_length;
	logic [1:0] ack_code;

	// Bytes waiting to be sent and results the deframer owes us
	logic [7:0] rx_stream_q[$];
	dpd_pkg::result_t deframed_q[$];

	// Tracked deframer state
	dpd_pkg::phase_t trk_phase = dpd_pkg::PH_HUNT;
	logic [7:0] trk_sum = '0;
	logic [dpd_pkg::COUNT_W:0] trk_count = '0;
	logic [3:0] trk_nibble = '0;
	logic trk_hi_ok = 1'b0;
	logic trk_no_ack = 1'b0;

	int gap_pct = 0;
	int stall_pct = 0;
	int n_errors = 0;
	int stuck_cycles = 0;

	debug_packet_deframer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.no_ack_we(no_ack_we),
		.no_ack_wdata(no_ack_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.data_byte(data_byte),
		.payload_length(payload_length),
		.ack_code(ack_code)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// {valid, value} of an ASCII hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
		if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
		if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
		return 5'b0;
	endfunction

	// Advance the tracked framing state by one byte, queue any result it yields
	function automatic void deframe_byte(input logic [7:0] b);
		dpd_pkg::result_t r;
		logic [4:0] hv;
		logic [dpd_pkg::LEN_W-1:0] len_now;
		r = '0;
		len_now = (trk_count > dpd_pkg::LEN_MAX) ? dpd_pkg::LEN_W'(dpd_pkg::LEN_MAX) :
			trk_count[dpd_pkg::LEN_W-1:0];
		case (trk_phase)
			dpd_pkg::PH_HUNT: begin
				if (b == dpd_pkg::CH_START) begin
					trk_phase = dpd_pkg::PH_DATA;
					trk_sum = '0;
					trk_count = '0;
				end
			end
			dpd_pkg::PH_DATA: begin
				if (b == dpd_pkg::CH_END) begin
					trk_phase = dpd_pkg::PH_DIG1;
				end else if (trk_count + 1 >= dpd_pkg::PAYLOAD_CAP) begin
					// full: byte dropped, packet abandoned
					r.kind = dpd_pkg::KIND_OVERFLOW;
					r.len = len_now;
					r.ack = dpd_pkg::ACK_NONE;
					deframed_q.push_back(r);
					trk_phase = dpd_pkg::PH_HUNT;
				end else begin
					trk_count = trk_count + 1'b1;
					trk_sum = trk_sum + b;
					r.kind = dpd_pkg::KIND_DATA;
					r.data = b;
					r.ack = dpd_pkg::ACK_NONE;
					deframed_q.push_back(r);
				end
			end
			dpd_pkg::PH_DIG1: begin
				hv = hex_digit(b);
				trk_hi_ok = hv[4];
				trk_nibble = hv[4] ? hv[3:0] : 4'h0;
				trk_phase = dpd_pkg::PH_DIG2;
			end
			default: begin
				hv = hex_digit(b);
				trk_phase = dpd_pkg::PH_HUNT;
				r.len = len_now;
				if (!hv[4] || !trk_hi_ok) begin
					r.kind = dpd_pkg::KIND_BAD_DIGIT;
					r.ack = dpd_pkg::ACK_NONE;
				end else if ({trk_nibble, hv[3:0]} == trk_sum) begin
					r.kind = dpd_pkg::KIND_GOOD;
					r.ack = trk_no_ack ? dpd_pkg::ACK_NONE : dpd_pkg::ACK_PLUS;
				end else begin
					r.kind = dpd_pkg::KIND_MISMATCH;
					r.ack = trk_no_ack ? dpd_pkg::ACK_NONE : dpd_pkg::ACK_MINUS;
				end
				deframed_q.push_back(r);
			end
		endcase
	endfunction

	function automatic void note_error();
		n_errors++;
	endfunction

	// Compare one result leaving the deframer with the oldest one owed
	function automatic void check_result();
		dpd_pkg::result_t want;
		if (deframed_q.size() == 0) begin
			if (n_errors < PRINT_CAP)
				$display("%0t: unexpected result kind=%0d data=%h len=%0d ack=%0d", $time,
					result_kind, data_byte, payload_length, ack_code);
			note_error();
			return;
		end
		want = deframed_q.pop_front();
		if (result_kind !== want.kind) begin
			if (n_errors < PRINT_CAP)
				$display("%0t: result_kind expected %0d got %0d", $time, want.kind, result_kind);
			note_error();
		end
		if (data_byte !== want.data) begin
			if (n_errors < PRINT_CAP)
				$display("%0t: data_byte expected %h got %h", $time, want.data, data_byte);
			note_error();
		end
		if (payload_length !== want.len) begin
			if (n_errors < PRINT_CAP)
				$display("%0t: payload_length expected %0d got %0d", $time, want.len,
					payload_length);
			note_error();
		end
		if (ack_code !== want.ack) begin
			if (n_errors < PRINT_CAP)
				$display("%0t: ack_code expected %0d got %0d", $time, want.ack, ack_code);
			note_error();
		end
	endfunction

	// Sender: hold a stalled request, otherwise maybe present the next byte
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				deframe_byte(rx_byte);
			end
			if (!in_valid || !in_stall) begin
				if (rx_stream_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
					rx_byte <= rx_stream_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: take results, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				check_result();
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog on traffic
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no traffic for %0d cycles", $time, STUCK_LIMIT);
			$display("debug_packet_deframer test failed");
			$finish;
		end
	end

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) rx_stream_q.push_back(s[i]);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'("0" + n);
		return 8'(($urandom_range(1) ? "a" : "A") + n - 4'd10);
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		logic [4:0] v;
		do begin
			c = 8'($urandom);
			v = hex_digit(c);
		end while (v[4]);
		return c;
	endfunction

	// One packet with optional leading noise; most are well formed, some are
	// cut short, carry a wrong checksum or a non-hex digit
	task automatic queue_packet(input int body_len, inout int counted);
		logic [7:0] sum;
		logic [7:0] b;
		int pick;
		int which;
		sum = '0;
		pick = $urandom_range(99);
		which = $urandom_range(2);
		repeat ($urandom_range(0, 1) ? $urandom_range(2) : $urandom_range(12))
			rx_stream_q.push_back(8'($urandom));
		rx_stream_q.push_back(dpd_pkg::CH_START);
		for (int i = 0; i < body_len; i++) begin
			do begin
				b = ($urandom_range(19) == 0) ? dpd_pkg::CH_START : 8'($urandom);
			end while (b == dpd_pkg::CH_END);
			sum = sum + b;
			rx_stream_q.push_back(b);
		end
		counted += body_len + 1;
		if (pick < 6) return;
		rx_stream_q.push_back(dpd_pkg::CH_END);
		if (pick < 74) begin
			rx_stream_q.push_back(hex_char(sum[7:4]));
			rx_stream_q.push_back(hex_char(sum[3:0]));
		end else if (pick < 88) begin
			sum = sum ^ 8'($urandom_range(1, 255));
			rx_stream_q.push_back(hex_char(sum[7:4]));
			rx_stream_q.push_back(hex_char(sum[3:0]));
		end else begin
			rx_stream_q.push_back(which == 1 ? hex_char(sum[7:4]) : junk_char());
			rx_stream_q.push_back(which == 0 ? hex_char(sum[3:0]) : junk_char());
		end
		counted += 3;
	endtask

	// Register write while the deframer is idle
	task automatic set_no_ack(input logic v);
		@(posedge clk);
		no_ack_we <= 1'b1;
		no_ack_wdata <= v;
		@(posedge clk);
		no_ack_we <= 1'b0;
		trk_no_ack = v;
	endtask

	// Everything sent and answered, then let trailing hunt bytes pass through
	task automatic wait_drained();
		while (rx_stream_q.size() != 0 || in_valid || deframed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int counted;
		int mode;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: stray byte, '$' inside payload, byte extremes, good,
		// mismatch, lower-case digits, bad first and bad second digit
		set_no_ack(1'b0);
		push_text("x$");
		rx_stream_q.push_back(8'h00);
		rx_stream_q.push_back(8'hFF);
		push_text("$#23$A#42$");
		rx_stream_q.push_back(8'hD6);
		push_text("#d6$#g0$#FZ");
		wait_drained();

		// Random phases: each idle pattern under both ack settings
		for (int ph = 0; ph < PHASES; ph++) begin
			mode = ph % 4;
			gap_pct = (mode == 1) ? 45 : (mode == 3) ? 6 : 0;
			stall_pct = (mode == 2) ? 45 : (mode == 3) ? 6 : 0;
			set_no_ack(1'((ph % 2) ^ (ph / 4)));
			counted = 0;
			// one packet long enough to hit the capacity limit
			if (ph == 5) queue_packet(dpd_pkg::PAYLOAD_CAP + $urandom_range(3), counted);
			while (counted < PHASE_BYTES) begin
				if ($urandom_range(9) == 0) queue_packet($urandom_range(80), counted);
				else queue_packet($urandom_range(12), counted);
			end
			wait_drained();
		end

		if (n_errors == 0 && deframed_q.size() == 0) begin
			$display("debug_packet_deframer test passed");
		end else begin
			if (deframed_q.size() != 0)
				$display("%0t: %0d results never arrived", $time, deframed_q.size());
			$display("debug_packet_deframer test failed");
		end
		$finish;
	end

endmodule
